>>> design/rflru_pkg.sv
package rflru_pkg;

  // field widths
  localparam int unsigned MacW   = 48;
  localparam int unsigned SeqW   = 32;
  localparam int unsigned StampW = 32;

  // one table entry as kept in the table memory
  typedef struct packed {
    logic [MacW-1:0]   mac;
    logic [SeqW-1:0]   seq;
    logic [StampW-1:0] stamp;
  } entry_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

endpackage

>>> design/replay_filter_lru_table_unit.sv
// Replay filter with a least-recently-used origin table.
// Input channel: in_valid_i / in_stall_o carry origin_mac_i and sequence_number_i.
// A transaction is taken when in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o / out_stall_i carry accepted_o and new_origin_o,
// exactly one result transaction for every input transaction, in order.
// Each item advances a 32-bit use clock, then the table is scanned one entry per
// cycle through a single read port with a registered read; one comparator pair
// checks the entry read in the previous cycle. A hit ends the scan early.
// A write-back cycle loads the output register and, unless the item is a replay,
// updates the entry. One item is in work at a time: a new item is taken only
// once the previous one has left the write-back state.
// in_stall_o is high while an item is in work. A finished result waits in the
// output register while out_stall_i is high; the next item may already be
// taken, and its write-back waits until the output register is free.
// Reset clears the valid bits, the use clock and the sequencer at once; the
// table memory itself needs no clearing pass.
module replay_filter_lru_table_unit #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rflru_pkg::MacW-1:0]  origin_mac_i,
  input  logic [rflru_pkg::SeqW-1:0]  sequence_number_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        accepted_o,
  output logic                        new_origin_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  rflru_pkg::state_e state_q, state_d;

  // table storage
  rflru_pkg::entry_t mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;

  // item registers
  logic [rflru_pkg::MacW-1:0]   mac_q;
  logic [rflru_pkg::SeqW-1:0]   seq_q;
  logic [rflru_pkg::StampW-1:0] use_clock_q;

  // scan registers
  logic [IdxW-1:0]              scan_idx_q;
  logic                         issue_done_q;
  logic                         chk_vld_q;
  logic [IdxW-1:0]              chk_idx_q;
  rflru_pkg::entry_t            rdata_q;
  logic                         free_found_q;
  logic [IdxW-1:0]              free_idx_q;
  logic [IdxW-1:0]              old_idx_q;
  logic [rflru_pkg::StampW-1:0] old_stamp_q;
  logic                         hit_q;
  logic [IdxW-1:0]              hit_idx_q;
  logic [rflru_pkg::SeqW-1:0]   hit_seq_q;

  // output register
  logic out_valid_q;
  logic accepted_q;
  logic new_origin_q;

  // control
  logic            in_acc;
  logic            issue;
  logic            chk_hit;
  logic            chk_last;
  logic            out_free;
  logic            wr_go;
  logic            replay;
  logic [IdxW-1:0] wr_idx;

  assign in_stall_o   = (state_q != rflru_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign accepted_o   = accepted_q;
  assign new_origin_o = new_origin_q;

  // control decode
  always_comb begin
    in_acc   = in_valid_i && (state_q == rflru_pkg::ST_IDLE);
    issue    = (state_q == rflru_pkg::ST_SCAN) && !issue_done_q;
    chk_hit  = chk_vld_q && valid_q[chk_idx_q] && (rdata_q.mac == mac_q);
    chk_last = chk_vld_q && (chk_idx_q == LastIdx);
    out_free = !out_valid_q || !out_stall_i;
    wr_go    = (state_q == rflru_pkg::ST_WRITE) && out_free;
    replay   = hit_q && (seq_q <= hit_seq_q);
    if (hit_q) begin
      wr_idx = hit_idx_q;
    end else if (free_found_q) begin
      wr_idx = free_idx_q;
    end else begin
      wr_idx = old_idx_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rflru_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = rflru_pkg::ST_SCAN;
      end
      rflru_pkg::ST_SCAN: begin
        if (chk_hit || chk_last) state_d = rflru_pkg::ST_WRITE;
      end
      rflru_pkg::ST_WRITE: begin
        if (out_free) state_d = rflru_pkg::ST_IDLE;
      end
      default: state_d = rflru_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rflru_pkg::ST_IDLE;
      valid_q      <= '0;
      use_clock_q  <= '0;
      out_valid_q  <= 1'b0;
      issue_done_q <= 1'b0;
      chk_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        use_clock_q  <= use_clock_q + 1'b1;
        issue_done_q <= 1'b0;
      end else if (issue && (scan_idx_q == LastIdx)) begin
        issue_done_q <= 1'b1;
      end
      // stop the compare stage once the scan has ended
      chk_vld_q <= issue && !chk_hit;
      if (wr_go && !replay) valid_q[wr_idx] <= 1'b1;
      if (wr_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item capture and scan datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mac_q        <= origin_mac_i;
      seq_q        <= sequence_number_i;
      scan_idx_q   <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      old_idx_q    <= '0;
      old_stamp_q  <= '1;
      hit_q        <= 1'b0;
    end else begin
      if (issue && (scan_idx_q != LastIdx)) scan_idx_q <= scan_idx_q + 1'b1;
      if (chk_vld_q) begin
        if (chk_hit) begin
          hit_q     <= 1'b1;
          hit_idx_q <= chk_idx_q;
          hit_seq_q <= rdata_q.seq;
        end else begin
          // lowest free slot
          if (!valid_q[chk_idx_q] && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= chk_idx_q;
          end
          // oldest stamp, lowest index on a tie
          if (rdata_q.stamp < old_stamp_q) begin
            old_stamp_q <= rdata_q.stamp;
            old_idx_q   <= chk_idx_q;
          end
        end
      end
    end
    chk_idx_q <= scan_idx_q;
  end

  // table memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (issue) rdata_q <= mem_q[scan_idx_q];
    if (wr_go && !replay) begin
      mem_q[wr_idx] <= '{mac: mac_q, seq: seq_q, stamp: use_clock_q};
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (wr_go) begin
      accepted_q   <= !replay;
      new_origin_q <= !hit_q;
    end
  end

`ifndef SYNTH
  a_clock_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> use_clock_q == $past(use_clock_q) + 1'b1)
    else $error("use clock did not advance by one per transaction");

  a_new_implies_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && new_origin_o |-> accepted_o)
    else $error("new origin reported on a rejected transaction");

  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_go |=> out_valid_o && (state_q == rflru_pkg::ST_IDLE))
    else $error("write-back did not load the output register");

  a_chk_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> state_q == rflru_pkg::ST_SCAN)
    else $error("compare stage active outside the scan");

  a_insert_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_go && !hit_q && free_found_q |-> !valid_q[free_idx_q])
    else $error("insert targets a slot that is already in use");
`endif

endmodule

>>> tb/testbench.sv
module testbench;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned PoolMax      = 32;
  localparam int unsigned PhaseCount   = 12;
  localparam int unsigned PhaseItems   = 120;

  typedef logic [rflru_pkg::MacW-1:0] mac_t;
  typedef logic [rflru_pkg::SeqW-1:0] seq_t;
  typedef logic [rflru_pkg::StampW-1:0] stamp_t;

  // one expected verdict of the filter
  typedef struct packed {
    logic accepted;
    logic new_origin;
  } verdict_t;

  // origin table predictor and queue of expected verdicts
  class replay_scoreboard;
    bit       slot_used[TableEntries];
    mac_t     slot_mac[TableEntries];
    seq_t     slot_seq[TableEntries];
    stamp_t   slot_stamp[TableEntries];
    stamp_t   use_count;
    verdict_t verdicts[$];

    function new();
      for (int k = 0; k < TableEntries; k++) begin
        slot_used[k]  = 1'b0;
        slot_mac[k]   = '0;
        slot_seq[k]   = '0;
        slot_stamp[k] = '0;
      end
      use_count = '0;
    endfunction

    // look up the origin, update the table and queue the verdict
    function void note_input(mac_t mac, seq_t seq);
      int       hit = -1;
      int       free_slot = -1;
      int       oldest = 0;
      int       target;
      stamp_t   oldest_stamp = '1;
      verdict_t v;
      use_count = use_count + 1'b1;
      for (int k = 0; k < TableEntries; k++) begin
        if (hit < 0) begin
          if (slot_used[k] && slot_mac[k] == mac) begin
            hit = k;
          end else begin
            if (!slot_used[k] && free_slot < 0) free_slot = k;
            if (slot_stamp[k] < oldest_stamp) begin
              oldest_stamp = slot_stamp[k];
              oldest = k;
            end
          end
        end
      end
      if (hit >= 0) begin
        // replay leaves the entry untouched
        if (seq <= slot_seq[hit]) begin
          v = '{accepted: 1'b0, new_origin: 1'b0};
        end else begin
          slot_seq[hit]   = seq;
          slot_stamp[hit] = use_count;
          v = '{accepted: 1'b1, new_origin: 1'b0};
        end
      end else begin
        // unknown origin: first free slot, else least recently used
        target = (free_slot >= 0) ? free_slot : oldest;
        slot_used[target]  = 1'b1;
        slot_mac[target]   = mac;
        slot_seq[target]   = seq;
        slot_stamp[target] = use_count;
        v = '{accepted: 1'b1, new_origin: 1'b1};
      end
      verdicts.push_back(v);
    endfunction

    // compare one result with the oldest expected verdict
    function bit check_result(logic acc, logic nw, output string msg);
      verdict_t want;
      msg = "";
      if (verdicts.size() == 0) begin
        msg = "result with no transaction waiting";
        return 1'b0;
      end
      want = verdicts.pop_front();
      if (acc !== want.accepted)
        msg = $sformatf("accepted %b, want %b", acc, want.accepted);
      if (nw !== want.new_origin)
        msg = $sformatf("%s new_origin %b, want %b", msg, nw, want.new_origin);
      return msg == "";
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni            = 1'b0;
  logic in_valid_i        = 1'b0;
  logic in_stall_o;
  mac_t origin_mac_i      = '0;
  seq_t sequence_number_i = '0;
  logic out_valid_o;
  logic out_stall_i       = 1'b0;
  logic accepted_o;
  logic new_origin_o;

  replay_scoreboard sb;
  int unsigned      errors = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      stall_left = 0;
  bit               in_quiet = 1'b0;
  bit               out_quiet = 1'b0;
  mac_t             pool[PoolMax];
  seq_t             seq_hint[PoolMax];

  replay_filter_lru_table_unit #(
    .TABLE_ENTRIES(TableEntries)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .origin_mac_i     (origin_mac_i),
    .sequence_number_i(sequence_number_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .accepted_o       (accepted_o),
    .new_origin_o     (new_origin_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // idle gap before a transaction, mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (in_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // drive one input transaction and wait until it is taken
  task automatic send_item(input mac_t mac, input seq_t seq);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    origin_mac_i      <= mac;
    sequence_number_i <= seq;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(mac, seq);
  endtask

  // hold the sender until every expected result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // one phase of random traffic over a pool of origins
  task automatic random_phase(input int unsigned n_items);
    int unsigned pool_size;
    int unsigned idx;
    int unsigned r;
    mac_t        mac;
    seq_t        seq;
    case ($urandom_range(0, 5))
      0: pool_size = 4;
      1: pool_size = 12;
      2: pool_size = 16;
      3: pool_size = 17;
      4: pool_size = 24;
      default: pool_size = PoolMax;
    endcase
    // near-identical origins test the full address compare
    for (int i = 0; i < pool_size; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0)
        pool[i] = pool[i-1] ^ (mac_t'(1) << $urandom_range(0, rflru_pkg::MacW - 1));
      else
        pool[i] = {16'($urandom), 32'($urandom)};
      seq_hint[i] = ($urandom_range(0, 3) == 0) ? seq_t'($urandom) : seq_t'($urandom_range(0, 100));
    end
    in_quiet  = ($urandom_range(0, 4) == 0);
    out_quiet = ($urandom_range(0, 4) == 0);
    for (int n = 0; n < n_items; n++) begin
      r   = $urandom_range(0, 99);
      idx = $urandom_range(0, pool_size - 1);
      mac = pool[idx];
      if (r < 60) seq = seq_hint[idx] + seq_t'($urandom_range(1, 5));
      else if (r < 75) seq = seq_hint[idx] - seq_t'($urandom_range(0, 3));
      else if (r < 85) seq = seq_t'($urandom);
      else if (r < 95) begin
        mac = {16'($urandom), 32'($urandom)};
        seq = seq_t'($urandom);
      end else seq = $urandom_range(0, 1) ? '1 : '0;
      send_item(mac, seq);
      if (mac == pool[idx] && seq > seq_hint[idx]) seq_hint[idx] = seq;
    end
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    int unsigned r;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall_i <= 1'b0;
        stall_left  <= $urandom_range(0, 8);
      end else if (r < 94) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 3);
      end else begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(10, 60);
      end
    end
  end

  // result check
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (!sb.check_result(accepted_o, new_origin_o, msg)) report(msg);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("replay_filter_lru_table_unit regression: fail");
      $finish;
    end
  end

  // stimulus
  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, replay with equal and lower sequence
    send_item('0, '0);
    send_item('0, '0);
    send_item('0, 32'd1);
    send_item('1, '1);
    send_item('1, '1);
    send_item('1, '0);
    send_item('0, '0);
    send_item(48'h1, 32'd5);
    // fill the table with walking-one origins
    for (int k = 1; k <= 13; k++)
      send_item(mac_t'(1) << (3 * k), seq_t'(1) << (2 * k));
    // table full: evictions pick the least recently used slot
    send_item(48'hA5A5_5A5A_C3C3, 32'h8000_0000);
    send_item('0, '0);
    send_item(48'h1, 32'd6);
    drain_results();

    for (int p = 0; p < PhaseCount; p++) begin
      random_phase(PhaseItems);
      if (p % 3 == 2) drain_results();
    end

    drain_results();
    repeat (30) @(posedge clk_i);
    if (sb.pending() != 0) report($sformatf("%0d results never arrived", sb.pending()));
    if (errors == 0)
      $display("replay_filter_lru_table_unit regression: pass");
    else
      $display("replay_filter_lru_table_unit regression: fail");
    $finish;
  end

endmodule

>>> replay_filter_lru_table_unit.f
design/rflru_pkg.sv
design/replay_filter_lru_table_unit.sv
tb/testbench.sv
